### hdl/assert_macros.svh
// Assertion macros shared by the deframer RTL.
// Simulation builds get the checks; synthesis builds define SYNTH and get empty bodies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

`define PDC_ASSERT(name, clk, rst, prop) \
   name: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("%m: assertion failed");

`define PDC_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("%m: assertion failed");

`else

`define PDC_ASSERT(name, clk, rst, prop)

`define PDC_ASSERT_NEXT(name, clk, rst, ante, cons)

`endif

`endif

### hdl/pdc_pkg.sv
// Shared types and constants for the packet deframer with checksum.
// No dependencies; every module imports this package.
package pdc_pkg;

   localparam int STORE_DEPTH = 64;
   localparam int ADDR_W      = $clog2(STORE_DEPTH);

   localparam logic [7:0] MAX_PAYLOAD    = 8'd64;
   localparam logic [7:0] HEADER_BYTE    = 8'hAF;
   localparam logic [6:0] STORE_DEPTH_V  = 7'(STORE_DEPTH);

   localparam logic REG_ADDRESSING = 1'b0;
   localparam logic REG_RX_LIMIT   = 1'b1;

   typedef enum logic [1:0] {
      KIND_PAYLOAD = 2'd0,
      KIND_EMPTY   = 2'd1,
      KIND_OVER    = 2'd2
   } kind_type;

   typedef struct packed {
      logic              start;
      kind_type          kind;
      logic [6:0]        length;
      logic [7:0]        src;
      logic [7:0]        dst;
   } drain_cmd_type;

   typedef struct packed {
      logic busy;
   } drain_status_type;

   typedef struct packed {
      logic              en;
      logic [ADDR_W-1:0] addr;
      logic [7:0]        data;
   } ram_wr_type;

   typedef struct packed {
      logic              en;
      logic [ADDR_W-1:0] addr;
   } ram_rd_type;

   typedef struct packed {
      kind_type          kind;
      logic [7:0]        data;
      logic [5:0]        idx;
      logic              last;
      logic [6:0]        length;
      logic [7:0]        src;
      logic [7:0]        dst;
   } result_type;

endpackage

### hdl/pdc_payload_ram.sv
// Payload buffer: one write port and one registered read port.
// Depends on pdc_pkg.
module pdc_payload_ram (
   input  logic               clock,
   input  pdc_pkg::ram_wr_type wr,
   input  pdc_pkg::ram_rd_type rd,
   output logic [7:0]         rd_data
);
   import pdc_pkg::*;

   logic [7:0] mem [STORE_DEPTH];
   logic [7:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr] <= wr.data;
      end
      if (rd.en) begin
         rd_data_ff <= mem[rd.addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### hdl/pdc_parser.sv
// Frame parser: header hunt, length, addresses, payload capture and checksum test.
// Depends on pdc_pkg; writes the payload buffer and starts the drain unit.
module pdc_parser (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic [7:0]                req_rx_byte,
   input  logic                      addressing_on,
   input  logic [6:0]                rx_limit,
   input  pdc_pkg::drain_status_type drain_status,
   output pdc_pkg::ram_wr_type       ram_wr,
   output pdc_pkg::drain_cmd_type    drain_cmd
);
   import pdc_pkg::*;

   typedef enum logic [2:0] {
      PH_HUNT    = 3'd0,
      PH_LENGTH  = 3'd1,
      PH_DEST    = 3'd2,
      PH_PAYLOAD = 3'd3,
      PH_SRC     = 3'd4,
      PH_CHECK   = 3'd5
   } phase_type;

   phase_type  phase_ff, phase_in;
   logic [6:0] exp_len_ff, exp_len_in;
   logic [6:0] taken_ff, taken_in;
   logic [7:0] sum_ff, sum_in;
   logic [7:0] dest_ff, dest_in;
   logic [7:0] src_ff, src_in;

   logic       accept;
   logic [7:0] sum_plus;
   logic [6:0] taken_next;
   logic       good;
   logic       over;
   phase_type  after_payload;

   assign req_ready     = !drain_status.busy;
   assign accept        = req_valid && req_ready;
   assign sum_plus      = sum_ff + req_rx_byte;
   assign taken_next    = taken_ff + 7'd1;
   assign good          = (sum_plus == 8'd0);
   assign over          = (exp_len_ff > rx_limit) || (exp_len_ff > STORE_DEPTH_V);
   assign after_payload = addressing_on ? PH_SRC : PH_CHECK;

   always_comb begin
      phase_in   = phase_ff;
      exp_len_in = exp_len_ff;
      taken_in   = taken_ff;
      sum_in     = sum_ff;
      dest_in    = dest_ff;
      src_in     = src_ff;
      ram_wr.en   = 1'b0;
      ram_wr.addr = taken_ff[ADDR_W-1:0];
      ram_wr.data = req_rx_byte;
      drain_cmd.start  = 1'b0;
      drain_cmd.kind   = KIND_PAYLOAD;
      drain_cmd.length = exp_len_ff;
      drain_cmd.src    = addressing_on ? src_ff : 8'd0;
      drain_cmd.dst    = addressing_on ? dest_ff : 8'd0;
      if (over) begin
         drain_cmd.kind = KIND_OVER;
      end else if (exp_len_ff == 7'd0) begin
         drain_cmd.kind = KIND_EMPTY;
      end
      if (accept) begin
         case (phase_ff)
            PH_LENGTH: begin
               if (req_rx_byte > MAX_PAYLOAD) begin
                  phase_in = PH_HUNT;
               end else begin
                  exp_len_in = req_rx_byte[6:0];
                  taken_in   = 7'd0;
                  dest_in    = 8'd0;
                  src_in     = 8'd0;
                  sum_in     = sum_plus;
                  if (addressing_on) begin
                     phase_in = PH_DEST;
                  end else if (req_rx_byte != 8'd0) begin
                     phase_in = PH_PAYLOAD;
                  end else begin
                     phase_in = PH_CHECK;
                  end
               end
            end
            PH_DEST: begin
               dest_in  = req_rx_byte;
               sum_in   = sum_plus;
               phase_in = (exp_len_ff != 7'd0) ? PH_PAYLOAD : after_payload;
            end
            PH_PAYLOAD: begin
               ram_wr.en = 1'b1;
               sum_in    = sum_plus;
               taken_in  = taken_next;
               if (taken_next >= exp_len_ff) begin
                  phase_in = after_payload;
               end
            end
            PH_SRC: begin
               src_in   = req_rx_byte;
               sum_in   = sum_plus;
               phase_in = PH_CHECK;
            end
            PH_CHECK: begin
               phase_in        = PH_HUNT;
               sum_in          = 8'd0;
               drain_cmd.start = over || good;
            end
            default: begin
               if (req_rx_byte == HEADER_BYTE) begin
                  sum_in   = HEADER_BYTE;
                  phase_in = PH_LENGTH;
               end else begin
                  phase_in = PH_HUNT;
               end
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_HUNT;
         exp_len_ff <= 7'd0;
         taken_ff   <= 7'd0;
         sum_ff     <= 8'd0;
         dest_ff    <= 8'd0;
         src_ff     <= 8'd0;
      end else begin
         phase_ff   <= phase_in;
         exp_len_ff <= exp_len_in;
         taken_ff   <= taken_in;
         sum_ff     <= sum_in;
         dest_ff    <= dest_in;
         src_ff     <= src_in;
      end
   end

endmodule

### hdl/pdc_drain.sv
// Drain unit: reads the payload buffer in order and queues results in a two-entry buffer.
// Depends on pdc_pkg; reads through the payload buffer's registered read port.
module pdc_drain (
   input  logic                      clock,
   input  logic                      reset,
   input  pdc_pkg::drain_cmd_type    drain_cmd,
   output pdc_pkg::drain_status_type drain_status,
   output pdc_pkg::ram_rd_type       ram_rd,
   input  logic [7:0]                ram_rd_data,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output pdc_pkg::result_type       rsp_result
);
   import pdc_pkg::*;

   logic       active_ff, active_in;
   kind_type   kind_ff, kind_in;
   logic [6:0] len_ff, len_in;
   logic [5:0] idx_ff, idx_in;
   logic [7:0] src_ff, src_in;
   logic [7:0] dst_ff, dst_in;

   logic       fl_valid_ff, fl_valid_in;
   kind_type   fl_kind_ff, fl_kind_in;
   logic [5:0] fl_idx_ff, fl_idx_in;
   logic       fl_last_ff, fl_last_in;

   result_type fifo_ff [2];
   logic       rd_ptr_ff, rd_ptr_in;
   logic       wr_ptr_ff, wr_ptr_in;
   logic [1:0] cnt_ff, cnt_in;

   logic       pop;
   logic       push;
   logic       step;
   logic       step_last;
   logic [1:0] occ;
   result_type push_result;

   assign pop       = (cnt_ff != 2'd0) && rsp_ready;
   assign push      = fl_valid_ff;
   assign occ       = cnt_ff + {1'b0, fl_valid_ff};
   assign step      = active_ff && (occ < (2'd2 + {1'b0, pop}));
   assign step_last = (kind_ff != KIND_PAYLOAD) || (({1'b0, idx_ff} + 7'd1) == len_ff);

   assign drain_status.busy = active_ff;
   assign ram_rd.en         = step && (kind_ff == KIND_PAYLOAD);
   assign ram_rd.addr       = idx_ff[ADDR_W-1:0];

   always_comb begin
      push_result.kind   = fl_kind_ff;
      push_result.data   = (fl_kind_ff == KIND_PAYLOAD) ? ram_rd_data : 8'd0;
      push_result.idx    = fl_idx_ff;
      push_result.last   = fl_last_ff;
      push_result.length = len_ff;
      push_result.src    = src_ff;
      push_result.dst    = dst_ff;
   end

   always_comb begin
      active_in   = active_ff;
      kind_in     = kind_ff;
      len_in      = len_ff;
      idx_in      = idx_ff;
      src_in      = src_ff;
      dst_in      = dst_ff;
      fl_valid_in = step;
      fl_kind_in  = kind_ff;
      fl_idx_in   = (kind_ff == KIND_PAYLOAD) ? idx_ff : 6'd0;
      fl_last_in  = step_last;
      if (drain_cmd.start) begin
         active_in = 1'b1;
         kind_in   = drain_cmd.kind;
         len_in    = drain_cmd.length;
         idx_in    = 6'd0;
         src_in    = drain_cmd.src;
         dst_in    = drain_cmd.dst;
      end else if (step) begin
         if (step_last) begin
            active_in = 1'b0;
         end else begin
            idx_in = idx_ff + 6'd1;
         end
      end
      rd_ptr_in = pop ? !rd_ptr_ff : rd_ptr_ff;
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      cnt_in    = cnt_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff   <= 1'b0;
         fl_valid_ff <= 1'b0;
         rd_ptr_ff   <= 1'b0;
         wr_ptr_ff   <= 1'b0;
         cnt_ff      <= 2'd0;
      end else begin
         active_ff   <= active_in;
         fl_valid_ff <= fl_valid_in;
         rd_ptr_ff   <= rd_ptr_in;
         wr_ptr_ff   <= wr_ptr_in;
         cnt_ff      <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff    <= kind_in;
      len_ff     <= len_in;
      idx_ff     <= idx_in;
      src_ff     <= src_in;
      dst_ff     <= dst_in;
      fl_kind_ff <= fl_kind_in;
      fl_idx_ff  <= fl_idx_in;
      fl_last_ff <= fl_last_in;
      if (push) begin
         fifo_ff[wr_ptr_ff] <= push_result;
      end
   end

   assign rsp_valid  = (cnt_ff != 2'd0);
   assign rsp_result = fifo_ff[rd_ptr_ff];

endmodule

### hdl/packet_deframer_checksum_unit.sv
// Top level of the byte-stream packet deframer with two's-complement checksum.
// Depends on pdc_pkg, pdc_parser, pdc_payload_ram, pdc_drain and assert_macros.svh.
//
// Received bytes are taken one per cycle while a frame is being parsed; payload bytes
// go into a 64-entry buffer RAM. When the checksum byte of a good or oversize frame is
// taken, the request side stops while the buffer is read out through its single read
// port, one result per cycle while the two-entry result queue has room; an empty or
// oversize frame gives a single result and no read. Bytes that follow are taken again
// as soon as the last result has been issued toward the queue, while queued results
// still wait. A frame with a bad checksum produces no result unless it is oversize;
// one longer than rx_limit produces a single oversize result, but a length byte above
// 64 sends the parser back to the header hunt. The buffer needs no clearing after reset.
`include "assert_macros.svh"

module packet_deframer_checksum_unit (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_rx_byte,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [1:0] rsp_kind,
   output logic [7:0] rsp_data_byte,
   output logic [5:0] rsp_byte_index,
   output logic       rsp_last,
   output logic [6:0] rsp_frame_length,
   output logic [7:0] rsp_source_address,
   output logic [7:0] rsp_destination_address,
   input  logic       csr_write_enable,
   input  logic       csr_index,
   input  logic [6:0] csr_write_data
);
   import pdc_pkg::*;

   logic             addressing_on_ff, addressing_on_in;
   logic [6:0]       rx_limit_ff, rx_limit_in;

   drain_cmd_type    drain_cmd;
   drain_status_type drain_status;
   ram_wr_type       ram_wr;
   ram_rd_type       ram_rd;
   logic [7:0]       ram_rd_data;
   result_type       rsp_result;
   logic             single_fields_ok;

   always_comb begin
      addressing_on_in = addressing_on_ff;
      rx_limit_in      = rx_limit_ff;
      if (csr_write_enable) begin
         case (csr_index)
            REG_ADDRESSING: addressing_on_in = csr_write_data[0];
            REG_RX_LIMIT:   rx_limit_in      = csr_write_data;
            default:        addressing_on_in = addressing_on_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         addressing_on_ff <= 1'b1;
         rx_limit_ff      <= 7'd64;
      end else begin
         addressing_on_ff <= addressing_on_in;
         rx_limit_ff      <= rx_limit_in;
      end
   end

   pdc_parser u_parser (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_rx_byte  (req_rx_byte),
      .addressing_on(addressing_on_ff),
      .rx_limit     (rx_limit_ff),
      .drain_status (drain_status),
      .ram_wr       (ram_wr),
      .drain_cmd    (drain_cmd)
   );

   pdc_payload_ram u_ram (
      .clock  (clock),
      .wr     (ram_wr),
      .rd     (ram_rd),
      .rd_data(ram_rd_data)
   );

   pdc_drain u_drain (
      .clock       (clock),
      .reset       (reset),
      .drain_cmd   (drain_cmd),
      .drain_status(drain_status),
      .ram_rd      (ram_rd),
      .ram_rd_data (ram_rd_data),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_result  (rsp_result)
   );

   assign rsp_kind                = rsp_result.kind;
   assign rsp_data_byte           = rsp_result.data;
   assign rsp_byte_index          = rsp_result.idx;
   assign rsp_last                = rsp_result.last;
   assign rsp_frame_length        = rsp_result.length;
   assign rsp_source_address      = rsp_result.src;
   assign rsp_destination_address = rsp_result.dst;

   assign single_fields_ok = (rsp_kind == KIND_PAYLOAD) ||
                             (rsp_last && rsp_data_byte == 8'd0 && rsp_byte_index == 6'd0);

   `PDC_ASSERT(a_start_when_idle, clock, reset, !drain_cmd.start || !drain_status.busy)
   `PDC_ASSERT(a_no_write_during_drain, clock, reset, !ram_wr.en || !drain_status.busy)
   `PDC_ASSERT_NEXT(a_start_makes_busy, clock, reset, drain_cmd.start, drain_status.busy)
   `PDC_ASSERT(a_single_result_fields, clock, reset, !rsp_valid || single_fields_ok)

endmodule
